### rtl/core/set_assoc_lru_cache_sim_macros.svh
// Assertion macros shared by the cache tag store RTL.
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/salc_pkg.sv
// Constants and codes for the set-associative LRU cache tag store.
package salc_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_FETCH  = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_STORE  = 2'd2;
  localparam logic [1:0] KIND_MODIFY = 2'd3;

  // Result outcomes.
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_WAYS_USED   = 2'd1;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

  // Field widths fixed by the interface.
  localparam int CFG_DATA_W = 6;
  localparam int CNT_W      = 32;
  localparam int IN_ADDR_W  = 64;

  typedef logic [CNT_W-1:0] count_t;

endpackage

### rtl/core/set_assoc_lru_cache_sim.sv
// Set-associative cache tag store with LRU replacement and saturating totals.
//
// Requests carry a kind (fetch, load, store, modify) and a byte address on a
// valid/stall channel; each request yields exactly one result (outcome plus
// hit, miss and eviction totals) on a second valid/stall channel.
// The tag store is one synchronous memory with a row per set holding the tag,
// valid bit and recency rank of every way. Accepting a request launches the
// row read; in the lookup state the row is searched in recency order, written
// back and the result register loaded. A modify needs no second lookup, as
// its store half always hits the way that was just made most recent. A new
// request is refused until the lookup of the last one finishes, as the set's
// row is read and then written back; the next request is taken while a result
// waits in the output register.
// When the receiver stalls a waiting result, a finished lookup holds off its
// write-back until the result register frees, and requests are refused
// meanwhile. Synchronous reset clears the per-set row flags at once, so every
// set reads as empty with ways in index order; there is no clearing pass.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle and
// does not flush the store.
`include "set_assoc_lru_cache_sim_macros.svh"

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int NUM_WAYS     = 8,
  parameter int ADDR_BITS    = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [salc_pkg::IN_ADDR_W-1:0]      address,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          outcome,
  output logic [salc_pkg::CNT_W-1:0]          hit_total,
  output logic [salc_pkg::CNT_W-1:0]          miss_total,
  output logic [salc_pkg::CNT_W-1:0]          eviction_total
);

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS   = 1 << SET_W;
  localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SB_W   = $clog2(MAX_SET_BITS + 8);
  localparam int USED_W = $clog2(NUM_WAYS + 16);

  // State codes.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  typedef struct packed {
    logic [NUM_WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [NUM_WAYS-1:0]                valid;
    logic [NUM_WAYS-1:0][RANK_W-1:0]    rank;
  } row_t;

  // Configuration registers.
  logic [2:0] set_bits;
  logic [3:0] ways_used;
  logic [5:0] offset_bits;

  // Control and request registers.
  logic                 state;
  logic [1:0]           kind_q;
  logic [SET_W-1:0]     set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic [SETS-1:0]      row_init;

  // Tag store memory.
  row_t mem [SETS];
  row_t row_rd;

  // Counters, which double as the result totals.
  salc_pkg::count_t hit_count;
  salc_pkg::count_t miss_count;
  salc_pkg::count_t evict_count;
  salc_pkg::count_t hit_count_next;
  salc_pkg::count_t miss_count_next;
  salc_pkg::count_t evict_count_next;

  // Address decode signals.
  logic [SB_W-1:0]      sb;
  logic [USED_W-1:0]    used;
  logic [ADDR_BITS-1:0] addr_cut;
  logic [ADDR_BITS-1:0] addr_off;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     set_calc;
  logic [ADDR_BITS-1:0] tag_calc;
  logic [6:0]           tag_shift;

  // Lookup signals.
  row_t              row_cur;
  row_t              row_new;
  logic              accept;
  logic              go;
  logic              mem_we;
  logic              found;
  logic [RANK_W-1:0] best_rank;
  logic [RANK_W-1:0] best_way;
  logic [RANK_W-1:0] worst_rank;
  logic [RANK_W-1:0] victim_way;
  logic [RANK_W-1:0] sel_way;
  logic [RANK_W-1:0] sel_rank;
  logic [1:0]        look_res;
  logic [1:0]        hit_inc;
  logic [32:0]       hit_sum;
  logic [32:0]       miss_sum;
  logic [32:0]       evict_sum;

  // Clamp the configuration to the built sizes.
  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_bits);
    end
    if (ways_used == 4'd0) begin
      used = USED_W'(1);
    end else if (int'(ways_used) > NUM_WAYS) begin
      used = USED_W'(NUM_WAYS);
    end else begin
      used = USED_W'(ways_used);
    end
  end

  // Split the incoming address into set index and tag.
  always_comb begin
    addr_cut  = address[ADDR_BITS-1:0];
    addr_off  = addr_cut >> offset_bits;
    set_mask  = ~({SET_W{1'b1}} << sb);
    set_calc  = addr_off[SET_W-1:0] & set_mask;
    tag_shift = 7'(offset_bits) + 7'(sb);
    tag_calc  = addr_cut >> tag_shift;
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign go       = (state == ST_LOOK) && (!out_valid || !out_stall);
  assign mem_we   = go && (kind_q != salc_pkg::KIND_FETCH);

  // A set never written reads as empty with ranks in way order.
  always_comb begin
    row_cur = row_rd;
    if (!row_init[set_q]) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        row_cur.tag[w]  = '0;
        row_cur.valid[w] = 1'b0;
        row_cur.rank[w] = RANK_W'(w);
      end
    end
  end

  // Search the ways in recency order; pick the LRU way when nothing fits.
  always_comb begin
    found      = 1'b0;
    best_rank  = '1;
    best_way   = '0;
    worst_rank = '0;
    victim_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (w < int'(used)) begin
        if ((!row_cur.valid[w] || (row_cur.tag[w] == tag_q)) &&
            (!found || (row_cur.rank[w] < best_rank))) begin
          found     = 1'b1;
          best_rank = row_cur.rank[w];
          best_way  = RANK_W'(w);
        end
        if (row_cur.rank[w] >= worst_rank) begin
          worst_rank = row_cur.rank[w];
          victim_way = RANK_W'(w);
        end
      end
    end
    sel_way  = found ? best_way : victim_way;
    sel_rank = row_cur.rank[sel_way];
    if (kind_q == salc_pkg::KIND_FETCH) begin
      look_res = salc_pkg::OUT_NONE;
    end else if (!found) begin
      look_res = salc_pkg::OUT_EVICT;
    end else if (row_cur.valid[sel_way]) begin
      look_res = salc_pkg::OUT_HIT;
    end else begin
      look_res = salc_pkg::OUT_MISS;
    end
  end

  // Promote the chosen way to most recent and write its tag.
  always_comb begin
    row_new = row_cur;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row_cur.rank[w] < sel_rank) begin
        row_new.rank[w] = row_cur.rank[w] + RANK_W'(1);
      end
    end
    row_new.rank[sel_way]  = '0;
    row_new.valid[sel_way] = 1'b1;
    row_new.tag[sel_way]   = tag_q;
  end

  // Saturating counter updates; the store half of a modify is one more hit.
  always_comb begin
    hit_inc = 2'((look_res == salc_pkg::OUT_HIT)) +
              2'((kind_q == salc_pkg::KIND_MODIFY));
    hit_sum   = {1'b0, hit_count} + 33'(hit_inc);
    miss_sum  = {1'b0, miss_count} + 33'((look_res == salc_pkg::OUT_MISS));
    evict_sum = {1'b0, evict_count} + 33'((look_res == salc_pkg::OUT_EVICT));
    hit_count_next   = hit_sum[32] ? '1 : hit_sum[31:0];
    miss_count_next  = miss_sum[32] ? '1 : miss_sum[31:0];
    evict_count_next = evict_sum[32] ? '1 : evict_sum[31:0];
  end

  // Tag store memory: row read on accept, write-back after the lookup.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_rd <= mem[set_calc];
    end
    if (mem_we) begin
      mem[set_q] <= row_new;
    end
  end

  // Request payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      set_q  <= set_calc;
      tag_q  <= tag_calc;
    end
    if (go) begin
      outcome <= look_res;
    end
  end

  // Control, configuration and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      row_init    <= '0;
      set_bits    <= 3'd0;
      ways_used   <= 4'd1;
      offset_bits <= 6'd0;
      hit_count   <= '0;
      miss_count  <= '0;
      evict_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          salc_pkg::CFG_SET_BITS:    set_bits    <= cfg_data[2:0];
          salc_pkg::CFG_WAYS_USED:   ways_used   <= cfg_data[3:0];
          salc_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (go) begin
            state       <= ST_IDLE;
            out_valid   <= 1'b1;
            hit_count   <= hit_count_next;
            miss_count  <= miss_count_next;
            evict_count <= evict_count_next;
          end
          if (mem_we) begin
            row_init[set_q] <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign hit_total      = hit_count;
  assign miss_total     = miss_count;
  assign eviction_total = evict_count;

  // Checks on the lookup sequence and counters.
  `SALC_ASSERT_NEXT(a_accept_to_look, accept, state == ST_LOOK, "accepted request did not start a lookup")
  `SALC_ASSERT_NEXT(a_look_to_result, go, out_valid && (state == ST_IDLE), "finished lookup produced no result")
  `SALC_ASSERT_NOW(a_counts_monotonic, !$past(rst) && !$past(go), $stable(hit_count) && $stable(miss_count) && $stable(evict_count), "counter changed without a lookup")

endmodule
